// ===== design/emb_pkg.sv =====
// ----------------------------------------------------------------------------
// emb_pkg
// Shared constants, types and tables of the model matrix builder.
// ----------------------------------------------------------------------------
package emb_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ANG_W            = 36;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259424;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629712;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518848;
    localparam logic signed [33:0]      CORDIC_K    = 34'sd652032874;

    localparam logic [15:0]        TAN_RST   = 16'd11051;
    localparam logic [15:0]        ASP_RST   = 16'd12288;
    localparam logic signed [31:0] DEPTH_RST = -32'sd6422528;

    localparam logic [1:0] REG_TAN   = 2'd0;
    localparam logic [1:0] REG_ASP   = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;

    typedef struct packed {
        logic [15:0] tag_id;
        logic [15:0] anchor_x;
        logic [15:0] anchor_y;
        logic [15:0] anchor_z;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] user_rotation;
        logic signed [31:0] depth_step;
    } emb_in_t;

    typedef struct packed {
        logic [15:0] object_id;
        logic [1:0]  column_index;
        logic signed [31:0] entry_row0;
        logic signed [31:0] entry_row1;
        logic signed [31:0] entry_row2;
        logic signed [31:0] entry_row3;
        logic        last_column;
    } emb_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } emb_cfg_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
               12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
               15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
               18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
               21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
               default: v = 32'h0;
            endcase
            atan_q30 = {4'b0, v};
        end
    endfunction

    // round a Q.30 product back to Q.30
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b + 68'sd536870912;
            mulq = 34'(p >>> 30);
        end
    endfunction

    // Q.30 to Q16.16 with half-up rounding; rotation terms never reach the clamp
    function automatic logic signed [31:0] rot_out(input logic signed [35:0] v);
        logic signed [35:0] r;
        begin
            r = (v + 36'sd8192) >>> 14;
            rot_out = 32'(r);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)       sat32 = 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
            else                           sat32 = 32'(v);
        end
    endfunction

endpackage

// ===== design/emb_if.sv =====
// ----------------------------------------------------------------------------
// emb_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface emb_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/emb_cordic.sv =====
// ----------------------------------------------------------------------------
// emb_cordic
// Pipelined sine/cosine CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module emb_cordic #(
    parameter int STEPS = emb_pkg::CORDIC_STEPS_DEF
) (
    input  logic clk,
    input  logic en,
    input  logic signed [emb_pkg::ANG_W-1:0] ang,
    output logic signed [33:0] sin_q,
    output logic signed [33:0] cos_q
);
    import emb_pkg::*;

    logic signed [ANG_W-1:0] a_reg [STEPS+1];
    logic signed [33:0]      x_reg [STEPS+1];
    logic signed [33:0]      y_reg [STEPS+1];
    logic                    n_reg [STEPS+1];
    logic signed [ANG_W-1:0] a0;
    logic                    n0;

    // fold wrapped angle into [-pi/2, pi/2]
    always_comb
    begin
        a0 = ang;
        n0 = 1'b0;
        if (ang > HALF_PI_Q30)
        begin
            a0 = ang - PI_Q30;
            n0 = 1'b1;
        end
        else if (ang < -HALF_PI_Q30)
        begin
            a0 = ang + PI_Q30;
            n0 = 1'b1;
        end
    end

    // load stage, then one micro-rotation per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= a0;
            x_reg[0] <= CORDIC_K;
            y_reg[0] <= '0;
            n_reg[0] <= n0;
            for (int i = 0; i < STEPS; i++)
            begin
                n_reg[i+1] <= n_reg[i];
                if (a_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sin_q = n_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
    assign cos_q = n_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
endmodule

// ===== design/euler_model_matrix_builder.sv =====
// ----------------------------------------------------------------------------
// euler_model_matrix_builder
// Builds a 4x4 model matrix per tracked anchor.
// ----------------------------------------------------------------------------
// Usage: each word on in_ch is one anchor; four words leave on out_ch, one
// per matrix column (0..3), last_column set on column 3. cfg_ch writes
// tan_half_fov (0), inv_aspect (1) or base_depth (2); others are ignored.
// Write registers only while the block is idle.
// Throughput: the output serializer sends one column per cycle while out_ch
// is ready and loads the next anchor as the last column is taken. The
// pipeline (angle wrap, CORDIC stages, two product stages, depth/extent
// stages) advances whenever its tail is free or its last stage is empty,
// so a receiver stall freezes all stages once an anchor waits at the end,
// without loss.
// Reset clears valid bits and col_reg, restores register defaults; nothing else.
// ----------------------------------------------------------------------------
module euler_model_matrix_builder #(
    parameter int CORDIC_STEPS = emb_pkg::CORDIC_STEPS_DEF
) (
    input logic clk,
    input logic rst_n,
    emb_if.sink   in_ch,
    emb_if.sink   cfg_ch,
    emb_if.source out_ch
);
    import emb_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 7;

    logic [15:0]        tan_reg, asp_reg;
    logic signed [31:0] base_reg;
    logic               en;
    logic [DEPTH-1:0]   vld_reg;
    logic [1:0]         col_reg;
    logic               obuf_vld_reg;

    // config registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tan_reg  <= TAN_RST;
            asp_reg  <= ASP_RST;
            base_reg <= DEPTH_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.data.index)
                REG_TAN:   tan_reg  <= cfg_ch.data.data[15:0];
                REG_ASP:   asp_reg  <= cfg_ch.data.data[15:0];
                REG_DEPTH: base_reg <= cfg_ch.data.data;
                default:   ;
            endcase
        end
    end

    // serializer: holds the tail word until its four columns are taken
    logic tail_busy;
    assign tail_busy = obuf_vld_reg && !(out_ch.ready && col_reg == 2'd3);
    assign en = !(vld_reg[DEPTH-1] && tail_busy);
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    // stage 0: angle sums and wrap
    logic signed [ANG_W-1:0] aa, ab, ac, wa, wb, wc;
    assign aa = ANG_W'(($signed({in_ch.data.yaw[15], in_ch.data.yaw})
                - $signed({in_ch.data.user_rotation[15], in_ch.data.user_rotation}))
                * 36'sd131072);
    assign ab = ANG_W'(in_ch.data.pitch) * 36'sd131072;
    assign ac = ANG_W'(in_ch.data.roll) * 36'sd131072 - HALF_PI_Q30;

    function automatic logic signed [ANG_W-1:0] wrap(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        begin
            r = a;
            if (r >= PI_Q30)       r = r - TWO_PI_Q30;
            else if (r < -PI_Q30)  r = r + TWO_PI_Q30;
            if (r < -PI_Q30)       r = r + TWO_PI_Q30;
            wrap = r;
        end
    endfunction

    logic signed [ANG_W-1:0] wa_reg, wb_reg, wc_reg;
    assign wa = wrap(aa);
    assign wb = wrap(ab);
    assign wc = wrap(ac);

    // depth path runs alongside, carried through a delay line
    logic signed [49:0] zp_reg;
    logic [15:0] ax_reg, ay_reg, id_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wa_reg <= wa;
            wb_reg <= wb;
            wc_reg <= wc;
            zp_reg <= ($signed({base_reg[31], base_reg})
                       + $signed({in_ch.data.depth_step[31], in_ch.data.depth_step}))
                      * $signed({1'b0, in_ch.data.anchor_z});
            ax_reg <= in_ch.data.anchor_x;
            ay_reg <= in_ch.data.anchor_y;
            id_reg <= in_ch.data.tag_id;
        end
    end

    logic signed [33:0] sa, ca, sb, cb, sc, cc;
    emb_cordic #(.STEPS(CORDIC_STEPS)) u_ca
        (.clk(clk), .en(en), .ang(wa_reg), .sin_q(sa), .cos_q(ca));
    emb_cordic #(.STEPS(CORDIC_STEPS)) u_cb
        (.clk(clk), .en(en), .ang(wb_reg), .sin_q(sb), .cos_q(cb));
    emb_cordic #(.STEPS(CORDIC_STEPS)) u_cc
        (.clk(clk), .en(en), .ang(wc_reg), .sin_q(sc), .cos_q(cc));

    // depth delay line alongside the CORDIC stages: z, anchor x/y and tag id
    localparam int DL = CORDIC_STEPS + 1;
    logic signed [37:0] z_reg   [DL];
    logic signed [39:0] y_e_reg;
    logic [15:0] axd_reg [DL];
    logic [15:0] ayd_reg [DL];
    logic [15:0] idd_reg [DL];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= 38'((zp_reg + 50'sd2048) >>> 12);
            axd_reg[0] <= ax_reg;
            ayd_reg[0] <= ay_reg;
            idd_reg[0] <= id_reg;
            for (int k = 1; k < DL; k++)
            begin
                z_reg[k]   <= z_reg[k-1];
                axd_reg[k] <= axd_reg[k-1];
                ayd_reg[k] <= ayd_reg[k-1];
                idd_reg[k] <= idd_reg[k-1];
            end
        end
    end

    // product stage 1 (aligned with CORDIC output)
    logic signed [33:0] p_cacb, p_casb, p_sasb, p_sacb, p_cbcc, p_cbsc;
    logic signed [33:0] sa1, ca1, sb1, sc1, cc1;
    logic signed [53:0] y_p;
    logic [15:0] ax1, ay1, id1;
    logic signed [37:0] z1;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cacb <= mulq(ca, cb);
            p_casb <= mulq(ca, sb);
            p_sasb <= mulq(sa, sb);
            p_sacb <= mulq(sa, cb);
            p_cbcc <= mulq(cb, cc);
            p_cbsc <= mulq(cb, sc);
            sa1 <= sa; ca1 <= ca; sb1 <= sb; sc1 <= sc; cc1 <= cc;
            y_p <= z_reg[DL-1] * $signed({1'b0, tan_reg});
            z1  <= z_reg[DL-1];
            ax1 <= axd_reg[DL-1];
            ay1 <= ayd_reg[DL-1];
            id1 <= idd_reg[DL-1];
        end
    end

    // product stage 2
    logic signed [33:0] q01a, q01b, q02a, q02b, q21a, q21b, q22a, q22b;
    logic signed [33:0] r00, r10, r11, r12, r20;
    logic signed [37:0] z2;
    logic [15:0] ax2, ay2, id2;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // negate before rounding: half-up rounding is not symmetric
            q01a <= mulq(-p_casb, cc1);
            q01b <= mulq(sa1, sc1);
            q02a <= mulq(p_casb, sc1);
            q02b <= mulq(sa1, cc1);
            q21a <= mulq(p_sasb, cc1);
            q21b <= mulq(ca1, sc1);
            q22a <= mulq(ca1, cc1);
            q22b <= mulq(p_sasb, sc1);
            r00 <= p_cacb;
            r10 <= sb1;
            r11 <= p_cbcc;
            r12 <= -p_cbsc;
            r20 <= -p_sacb;
            y_e_reg <= 40'((y_p + 54'sd8192) >>> 14);
            z2 <= z1; ax2 <= ax1; ay2 <= ay1; id2 <= id1;
        end
    end

    // stage 3: sums, xext product, and y translation product
    logic signed [31:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [55:0] x_p;
    logic signed [57:0] ty_p;
    logic signed [37:0] z3;
    logic [15:0] ax3, id3;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e00 <= rot_out(36'(r00));
            e01 <= rot_out(36'(q01a) + 36'(q01b));
            e02 <= rot_out(36'(q02a) + 36'(q02b));
            e10 <= rot_out(36'(r10));
            e11 <= rot_out(36'(r11));
            e12 <= rot_out(36'(r12));
            e20 <= rot_out(36'(r20));
            e21 <= rot_out(36'(q21a) + 36'(q21b));
            e22 <= rot_out(36'(q22a) - 36'(q22b));
            x_p  <= y_e_reg * $signed({1'b0, asp_reg});
            ty_p <= y_e_reg * (18'sd32768 - $signed({1'b0, ay2, 1'b0}));
            z3 <= z2; ax3 <= ax2; id3 <= id2;
        end
    end

    // stage 4: xext, y and z translations
    logic signed [31:0] f00, f01, f02, f10, f11, f12, f20, f21, f22;
    logic signed [31:0] ty4, tz4;
    logic signed [41:0] xe4;
    logic [15:0] ax4, id4;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {f00, f01, f02, f10, f11, f12, f20, f21, f22}
                <= {e00, e01, e02, e10, e11, e12, e20, e21, e22};
            xe4 <= 42'((x_p + 56'sd8192) >>> 14);
            ty4 <= sat32(64'((ty_p + 58'sd16384) >>> 15));
            tz4 <= sat32(64'(z3));
            ax4 <= ax3; id4 <= id3;
        end
    end

    // stage 5: x translation
    emb_out_t tmp;
    logic signed [59:0] tx_p;
    logic signed [31:0] ty5, tz5;
    logic signed [31:0] g [9];
    logic [15:0] id5;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_p <= xe4 * (18'sd32768 - $signed({1'b0, ax4, 1'b0}));
            g[0] <= f00; g[1] <= f01; g[2] <= f02;
            g[3] <= f10; g[4] <= f11; g[5] <= f12;
            g[6] <= f20; g[7] <= f21; g[8] <= f22;
            ty5 <= ty4; tz5 <= tz4; id5 <= id4;
        end
    end

    // tail register: full matrix, then column serializer; loads only when free
    logic signed [31:0] m_reg [9];
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic [15:0] oid_reg;
    always_ff @(posedge clk)
    begin
        if (!tail_busy)
        begin
            for (int k = 0; k < 9; k++)
                m_reg[k] <= g[k];
            tx_reg  <= sat32(64'((tx_p + 60'sd16384) >>> 15));
            ty_reg  <= ty5;
            tz_reg  <= tz5;
            oid_reg <= id5;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_vld_reg <= 1'b0;
            col_reg      <= 2'd0;
        end
        else
        begin
            if (!tail_busy)
                obuf_vld_reg <= vld_reg[DEPTH-1];
            if (obuf_vld_reg && out_ch.ready)
                col_reg <= col_reg + 2'd1;
        end
    end

    always_comb
    begin
        tmp.object_id    = oid_reg;
        tmp.column_index = col_reg;
        tmp.last_column  = (col_reg == 2'd3);
        case (col_reg)
            2'd0:
            begin
                tmp.entry_row0 = m_reg[0]; tmp.entry_row1 = m_reg[3];
                tmp.entry_row2 = m_reg[6]; tmp.entry_row3 = tx_reg;
            end
            2'd1:
            begin
                tmp.entry_row0 = m_reg[1]; tmp.entry_row1 = m_reg[4];
                tmp.entry_row2 = m_reg[7]; tmp.entry_row3 = ty_reg;
            end
            2'd2:
            begin
                tmp.entry_row0 = m_reg[2]; tmp.entry_row1 = m_reg[5];
                tmp.entry_row2 = m_reg[8]; tmp.entry_row3 = tz_reg;
            end
            default:
            begin
                tmp.entry_row0 = '0; tmp.entry_row1 = '0;
                tmp.entry_row2 = '0; tmp.entry_row3 = 32'sd65536;
            end
        endcase
    end

    assign out_ch.valid = obuf_vld_reg;
    assign out_ch.data  = tmp;

`ifndef SYNTH
    // column counter only moves while a word is shown
    a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !obuf_vld_reg |=> $stable(col_reg))
        else $error("column advanced with no word");
    // tail word cannot be replaced mid-matrix
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (obuf_vld_reg && col_reg != 2'd3) |-> !en || !vld_reg[DEPTH-1])
        else $error("tail overwritten mid-matrix");
    // a matrix that follows an idle tail starts at column 0
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(obuf_vld_reg) |-> col_reg == 2'd0)
        else $error("matrix not started at column 0");
`endif
endmodule

// ===== sim/emb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emb_checker
// Watches the anchor, register and column channels, computes each matrix from
// the register copy and compares every column word in full.
// ----------------------------------------------------------------------------
module emb_checker
    import emb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    emb_if.sink  in_mon,
    emb_if.sink  cfg_mon,
    emb_if.sink  out_mon,
    output int   fail_count,
    output int   pending,
    output int   columns_seen
);

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam longint PI_L   = 64'sd3373259424;
    localparam longint HPI_L  = 64'sd1686629712;
    localparam longint TPI_L  = 64'sd6746518848;

    logic [15:0]        fov_q;
    logic [15:0]        aspect_q;
    logic signed [31:0] depth_q;
    emb_out_t           column_q[$];

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(v);
    endfunction

    // CORDIC rotation with range reduction and half-turn fold
    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x, y, nx, a;
        bit     flip;
        x = 64'sd652032874;
        y = 0;
        a = ang;
        flip = 0;
        while (a >= PI_L) a -= TPI_L;
        while (a < -PI_L) a += TPI_L;
        if (a > HPI_L)
        begin
            a -= PI_L;
            flip = 1;
        end
        else if (a < -HPI_L)
        begin
            a += PI_L;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= longint'(atan_q30(i));
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += longint'(atan_q30(i));
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    // expected four column words of one anchor
    task automatic build_matrix(input emb_in_t w);
        longint sa, ca, sb, cb, sc, cc, z, yext, xext;
        longint r[3][3];
        longint t[3];
        emb_out_t o;
        cordic_sincos((longint'(w.yaw) - longint'(w.user_rotation)) * 131072, sa, ca);
        cordic_sincos(longint'(w.pitch) * 131072, sb, cb);
        cordic_sincos(longint'(w.roll) * 131072 - HPI_L, sc, cc);
        r[0][0] = q30_mul(ca, cb);
        r[0][1] = q30_mul(-q30_mul(ca, sb), cc) + q30_mul(sa, sc);
        r[0][2] = q30_mul(q30_mul(ca, sb), sc) + q30_mul(sa, cc);
        r[1][0] = sb;
        r[1][1] = q30_mul(cb, cc);
        r[1][2] = -q30_mul(cb, sc);
        r[2][0] = -q30_mul(sa, cb);
        r[2][1] = q30_mul(q30_mul(sa, sb), cc) + q30_mul(ca, sc);
        r[2][2] = q30_mul(ca, cc) - q30_mul(q30_mul(sa, sb), sc);
        z    = round_shift((longint'(depth_q) + longint'(w.depth_step))
                           * longint'({1'b0, w.anchor_z}), 12);
        yext = round_shift(z * longint'({1'b0, fov_q}), 14);
        xext = round_shift(yext * longint'({1'b0, aspect_q}), 14);
        t[0] = round_shift(xext * (32768 - 2 * longint'({1'b0, w.anchor_x})), 15);
        t[1] = round_shift(yext * (32768 - 2 * longint'({1'b0, w.anchor_y})), 15);
        t[2] = z;
        for (int k = 0; k < 4; k++)
        begin
            o.object_id    = w.tag_id;
            o.column_index = 2'(k);
            o.entry_row0   = (k < 3) ? clamp32(round_shift(r[0][k], 14)) : 32'sd0;
            o.entry_row1   = (k < 3) ? clamp32(round_shift(r[1][k], 14)) : 32'sd0;
            o.entry_row2   = (k < 3) ? clamp32(round_shift(r[2][k], 14)) : 32'sd0;
            o.entry_row3   = (k < 3) ? clamp32(t[k]) : 32'sd65536;
            o.last_column  = (k == 3);
            column_q.push_back(o);
        end
    endtask

    assign pending = column_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        emb_out_t exp_w;
        if (!rst_n)
        begin
            fov_q        <= TAN_RST;
            aspect_q     <= ASP_RST;
            depth_q      <= DEPTH_RST;
            fail_count   <= 0;
            columns_seen <= 0;
            column_q.delete();
        end
        else
        begin
            // register writes take effect for anchors accepted afterwards
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.data.index)
                    REG_TAN:   fov_q    <= cfg_mon.data.data[15:0];
                    REG_ASP:   aspect_q <= cfg_mon.data.data[15:0];
                    REG_DEPTH: depth_q  <= cfg_mon.data.data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                build_matrix(in_mon.data);
            // compare the column word against the oldest expectation
            if (out_mon.valid && out_mon.ready)
            begin
                columns_seen <= columns_seen + 1;
                if (column_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected column word %p", out_mon.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = column_q.pop_front();
                    if (exp_w !== out_mon.data)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: column mismatch exp %p got %p",
                                     exp_w, out_mon.data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives anchors and register writes into the model matrix builder under
// random bursts and receiver stalls; the checker gives the failure count.
// ----------------------------------------------------------------------------
module tb;
    import emb_pkg::*;

    localparam int LATENCY = CORDIC_STEPS_DEF + 9;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   columns_seen;
    int   anchors_sent;
    int   hold_cycles;
    bit   long_hold;

    emb_if #(emb_in_t)  in_ch ();
    emb_if #(emb_cfg_t) cfg_ch ();
    emb_if #(emb_out_t) out_ch ();

    euler_model_matrix_builder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    emb_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .cfg_mon      (cfg_ch),
        .out_mon      (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .columns_seen (columns_seen)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    // watchdog
    initial
    begin
        #20ms;
        $display("timeout");
        $display("tb failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        out_ch.ready = 0;
        hold_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 0;
                hold_cycles = hold_cycles + 1;
            end
            else
            begin
                case ((columns_seen / 64) % 3)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(12868 * ($urandom_range(0, 4) - 2)); // multiples of pi/2
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic emb_in_t random_anchor();
        emb_in_t w;
        w.tag_id        = 16'($urandom);
        w.anchor_x      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        w.anchor_y      = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        w.anchor_z      = 16'($urandom);
        w.roll          = pick_angle();
        w.pitch         = pick_angle();
        w.yaw           = pick_angle();
        w.user_rotation = pick_angle();
        case ($urandom_range(0, 3))
            0: w.depth_step = 32'($urandom);
            1: w.depth_step = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: w.depth_step = 32'(int'($urandom_range(0, 2000000)) - 1000000);
        endcase
        return w;
    endfunction

    task automatic send_anchor(input emb_in_t w);
        in_ch.data  <= w;
        in_ch.valid <= 1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        anchors_sent = anchors_sent + 1;
        @(negedge clk);
    endtask

    task automatic idle_sender(input int n);
        in_ch.valid <= 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.data.index <= idx;
        cfg_ch.data.data  <= val;
        cfg_ch.valid      <= 1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // random anchors in bursts with gaps
    task automatic random_phase(input int n);
        int left;
        left = n;
        while (left > 0)
        begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--)
            begin
                send_anchor(random_anchor());
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        emb_in_t w;
        rst_n = 0;
        long_hold = 0;
        anchors_sent = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: field extremes at reset settings
        w = '0;
        send_anchor(w);
        w = '1;
        send_anchor(w);
        w = '0;
        w.tag_id = 16'hFFFF;
        w.anchor_x = 16'd32768;
        w.anchor_y = 16'd32768;
        w.anchor_z = 16'hFFFF;
        w.roll = 16'sh7FFF;
        w.pitch = 16'sh8000;
        w.yaw = 16'sh7FFF;
        w.user_rotation = 16'sh8000;
        w.depth_step = 32'sh7FFFFFFF;
        send_anchor(w);
        w.depth_step = 32'sh80000000;
        w.anchor_x = 16'hFFFF;
        w.anchor_y = 16'hFFFF;
        send_anchor(w);
        w.anchor_x = 0;
        w.anchor_y = 0;
        w.roll = 16'sd12868;
        w.pitch = 16'sd12868;
        w.yaw = -16'sd25736;
        w.user_rotation = 16'sd25736;
        w.depth_step = 32'sd6422528;
        send_anchor(w);
        w.pitch = -16'sd12868;
        w.roll = 16'sd25736;
        send_anchor(w);
        drain();

        // register extremes, including an unused index
        write_reg(REG_TAN, 32'hFFFF);
        write_reg(REG_ASP, 32'hFFFF);
        write_reg(REG_DEPTH, 32'h7FFFFFFF);
        write_reg(2'd3, 32'hDEADBEEF);
        random_phase(12);
        drain();
        write_reg(REG_TAN, 32'h0);
        write_reg(REG_ASP, 32'h0);
        write_reg(REG_DEPTH, 32'h80000000);
        random_phase(12);
        drain();
        write_reg(REG_TAN, 32'($urandom));
        write_reg(REG_ASP, 32'($urandom));
        write_reg(REG_DEPTH, 32'($urandom));

        // long receiver hold-off while anchors keep coming, enough to fill the pipe
        long_hold = 1;
        fork
            random_phase(40);
            begin
                while (hold_cycles < 150) @(negedge clk);
                long_hold = 0;
            end
        join
        drain();

        write_reg(REG_TAN, 32'd11051);
        write_reg(REG_ASP, 32'd12288);
        write_reg(REG_DEPTH, -32'sd6422528);
        random_phase(130);
        drain();

        $display("Sent %0d anchors, checked %0d column words across five register settings.",
                 anchors_sent, columns_seen);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/emb_pkg.sv
design/emb_if.sv
design/emb_cordic.sv
design/euler_model_matrix_builder.sv
sim/emb_checker.sv
sim/tb.sv
